// ===== rtl/bhp_pkg.sv =====
// Shared types and constants for the bit file header parser.
// Holds the one-hot phase encoding, parser state and result structs.
// No dependencies.
package bhp_pkg;

    typedef enum logic [19:0] {
        PH_IDLE    = 20'h00001,
        PH_F1_LEN  = 20'h00002,
        PH_F1_BODY = 20'h00004,
        PH_F2_LEN  = 20'h00008,
        PH_F2_KEY  = 20'h00010,
        PH_F3_LEN  = 20'h00020,
        PH_F3_BODY = 20'h00040,
        PH_F4_KEY  = 20'h00080,
        PH_F4_LEN  = 20'h00100,
        PH_F4_BODY = 20'h00200,
        PH_F5_KEY  = 20'h00400,
        PH_F5_LEN  = 20'h00800,
        PH_F5_BODY = 20'h01000,
        PH_F6_KEY  = 20'h02000,
        PH_F6_LEN  = 20'h04000,
        PH_F6_BODY = 20'h08000,
        PH_F7_KEY  = 20'h10000,
        PH_F7_LEN  = 20'h20000,
        PH_PAYLOAD = 20'h40000,
        PH_ERROR   = 20'h80000
    } phase_t;

    // Result kind
    localparam logic [1:0] ST_HEADER  = 2'd0;
    localparam logic [1:0] ST_PAYLOAD = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Error codes
    localparam logic [4:0] ERR_NONE       = 5'd0;
    localparam logic [4:0] ERR_F1_LEN     = 5'd1;
    localparam logic [4:0] ERR_F2_LEN     = 5'd2;
    localparam logic [4:0] ERR_KEY_A      = 5'd3;
    localparam logic [4:0] ERR_F3_LONG    = 5'd4;
    localparam logic [4:0] ERR_F3_UNTERM  = 5'd5;
    localparam logic [4:0] ERR_KEY_B      = 5'd6;
    localparam logic [4:0] ERR_F4_LONG    = 5'd7;
    localparam logic [4:0] ERR_F4_UNTERM  = 5'd8;
    localparam logic [4:0] ERR_KEY_C      = 5'd9;
    localparam logic [4:0] ERR_F5_LEN     = 5'd10;
    localparam logic [4:0] ERR_F5_UNTERM  = 5'd11;
    localparam logic [4:0] ERR_KEY_D      = 5'd12;
    localparam logic [4:0] ERR_F6_LEN     = 5'd13;
    localparam logic [4:0] ERR_F6_UNTERM  = 5'd14;
    localparam logic [4:0] ERR_KEY_E      = 5'd15;
    localparam logic [4:0] ERR_F7_LONG    = 5'd16;

    // Key letters and fixed field lengths
    localparam logic [7:0]  KEY_A      = 8'h61;
    localparam logic [7:0]  KEY_B      = 8'h62;
    localparam logic [7:0]  KEY_C      = 8'h63;
    localparam logic [7:0]  KEY_D      = 8'h64;
    localparam logic [7:0]  KEY_E      = 8'h65;
    localparam logic [7:0]  STR_TERM   = 8'h00;
    localparam logic [31:0] F1_LEN_VAL = 32'd9;
    localparam logic [31:0] F2_LEN_VAL = 32'd1;
    localparam logic [31:0] F5_LEN_VAL = 32'd11;
    localparam logic [31:0] F6_LEN_VAL = 32'd9;
    localparam logic [15:0] SHORT_LEN_BYTES = 16'd2;
    localparam logic [15:0] LONG_LEN_BYTES  = 16'd4;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] field_count;
        logic [31:0] len_acc;
        logic [4:0]  saved_error;
        logic [31:0] payload_len;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:       PH_IDLE,
        field_count: 16'd0,
        len_acc:     32'd0,
        saved_error: ERR_NONE,
        payload_len: 32'd0
    };

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  error_code;
        logic [2:0]  field_id;
        logic [7:0]  out_byte;
        logic        header_done;
        logic [31:0] payload_length;
    } result_t;

    // Header field number of each phase; zero outside the header.
    function automatic logic [2:0] field_of(phase_t p);
        logic [2:0] f;
        unique case (p) inside
            PH_F1_LEN, PH_F1_BODY:            f = 3'd1;
            PH_F2_LEN, PH_F2_KEY:             f = 3'd2;
            PH_F3_LEN, PH_F3_BODY:            f = 3'd3;
            PH_F4_KEY, PH_F4_LEN, PH_F4_BODY: f = 3'd4;
            PH_F5_KEY, PH_F5_LEN, PH_F5_BODY: f = 3'd5;
            PH_F6_KEY, PH_F6_LEN, PH_F6_BODY: f = 3'd6;
            PH_F7_KEY, PH_F7_LEN:             f = 3'd7;
            default:                          f = 3'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/bhp_parse.sv =====
// Combinational next-state and result logic for one byte of the header parser.
// Depends on bhp_pkg.
module bhp_parse import bhp_pkg::*; #(
    parameter int SIZE_WIDTH = 32
) (
    input  parse_state_t          st_in,
    input  logic [SIZE_WIDTH-1:0] offset_in,
    input  logic [SIZE_WIDTH-1:0] fsize_in,
    input  logic                  start_req,
    input  logic [31:0]           total_bytes,
    input  logic [7:0]            data_byte,
    output parse_state_t          st_next,
    output logic [SIZE_WIDTH-1:0] offset_next,
    output logic [SIZE_WIDTH-1:0] fsize_next,
    output result_t               res
);

    localparam int CW = (SIZE_WIDTH > 32) ? SIZE_WIDTH : 32;

    parse_state_t          cur;
    logic [SIZE_WIDTH-1:0] off;
    logic [SIZE_WIDTH-1:0] fs;
    logic [SIZE_WIDTH-1:0] first;
    logic [15:0]           cnt1;
    logic [31:0]           acc_shift;
    logic                  too_long;
    logic                  body_end;
    logic                  in_header;
    logic [4:0]            err;
    logic [1:0]            status;
    logic                  done;

    always_comb begin
        // A start byte restarts the parse and is byte zero of the new file.
        if (start_req) begin
            cur       = STATE_RESET;
            cur.phase = PH_F1_LEN;
            fs        = SIZE_WIDTH'(total_bytes);
            off       = '0;
        end else begin
            cur = st_in;
            fs  = fsize_in;
            off = offset_in;
        end

        cnt1      = cur.field_count + 16'd1;
        acc_shift = (cur.field_count == 16'd0) ? {24'h0, data_byte}
                                               : {cur.len_acc[23:0], data_byte};
        body_end  = ({16'h0, cnt1} >= cur.len_acc);

        // Bytes left counted from the first byte of the length field.
        first    = off - ((cur.phase == PH_F7_LEN) ? SIZE_WIDTH'(LONG_LEN_BYTES - 16'd1)
                                                   : SIZE_WIDTH'(SHORT_LEN_BYTES - 16'd1));
        too_long = (first >= fs) || (CW'(acc_shift) >= CW'(fs - first));

        st_next   = cur;
        in_header = 1'b1;
        err       = ERR_NONE;
        status    = ST_HEADER;
        done      = 1'b0;

        unique case (cur.phase)
            PH_IDLE: begin
                in_header = 1'b0;
            end
            PH_PAYLOAD: begin
                in_header = 1'b0;
                status    = ST_PAYLOAD;
            end
            PH_ERROR: begin
                in_header = 1'b0;
                status    = ST_ERROR;
            end
            PH_F1_LEN, PH_F2_LEN, PH_F5_LEN, PH_F6_LEN: begin
                st_next.len_acc     = acc_shift;
                st_next.field_count = cnt1;
                if (cnt1 >= SHORT_LEN_BYTES) begin
                    st_next.field_count = 16'd0;
                    case (cur.phase)
                        PH_F1_LEN: begin
                            if (acc_shift != F1_LEN_VAL) err = ERR_F1_LEN;
                            st_next.phase = PH_F1_BODY;
                        end
                        PH_F2_LEN: begin
                            if (acc_shift != F2_LEN_VAL) err = ERR_F2_LEN;
                            st_next.phase = PH_F2_KEY;
                        end
                        PH_F5_LEN: begin
                            if (acc_shift != F5_LEN_VAL) err = ERR_F5_LEN;
                            st_next.phase = PH_F5_BODY;
                        end
                        default: begin
                            if (acc_shift != F6_LEN_VAL) err = ERR_F6_LEN;
                            st_next.phase = PH_F6_BODY;
                        end
                    endcase
                end
            end
            PH_F3_LEN, PH_F4_LEN: begin
                st_next.len_acc     = acc_shift;
                st_next.field_count = cnt1;
                if (cnt1 >= SHORT_LEN_BYTES) begin
                    st_next.field_count = 16'd0;
                    // Size check wins over the empty-string check.
                    if (cur.phase == PH_F3_LEN) begin
                        if (too_long)                 err = ERR_F3_LONG;
                        else if (acc_shift == 32'd0)  err = ERR_F3_UNTERM;
                        st_next.phase = PH_F3_BODY;
                    end else begin
                        if (too_long)                 err = ERR_F4_LONG;
                        else if (acc_shift == 32'd0)  err = ERR_F4_UNTERM;
                        st_next.phase = PH_F4_BODY;
                    end
                end
            end
            PH_F1_BODY, PH_F3_BODY, PH_F4_BODY, PH_F5_BODY, PH_F6_BODY: begin
                st_next.field_count = cnt1;
                if (body_end) begin
                    st_next.field_count = 16'd0;
                    case (cur.phase)
                        PH_F1_BODY: st_next.phase = PH_F2_LEN;
                        PH_F3_BODY: begin
                            if (data_byte != STR_TERM) err = ERR_F3_UNTERM;
                            st_next.phase = PH_F4_KEY;
                        end
                        PH_F4_BODY: begin
                            if (data_byte != STR_TERM) err = ERR_F4_UNTERM;
                            st_next.phase = PH_F5_KEY;
                        end
                        PH_F5_BODY: begin
                            if (data_byte != STR_TERM) err = ERR_F5_UNTERM;
                            st_next.phase = PH_F6_KEY;
                        end
                        default: begin
                            if (data_byte != STR_TERM) err = ERR_F6_UNTERM;
                            st_next.phase = PH_F7_KEY;
                        end
                    endcase
                end
            end
            PH_F2_KEY: begin
                if (data_byte != KEY_A) err = ERR_KEY_A;
                st_next.phase = PH_F3_LEN;
            end
            PH_F4_KEY: begin
                if (data_byte != KEY_B) err = ERR_KEY_B;
                st_next.phase = PH_F4_LEN;
            end
            PH_F5_KEY: begin
                if (data_byte != KEY_C) err = ERR_KEY_C;
                st_next.phase = PH_F5_LEN;
            end
            PH_F6_KEY: begin
                if (data_byte != KEY_D) err = ERR_KEY_D;
                st_next.phase = PH_F6_LEN;
            end
            PH_F7_KEY: begin
                if (data_byte != KEY_E) err = ERR_KEY_E;
                st_next.phase = PH_F7_LEN;
            end
            PH_F7_LEN: begin
                st_next.len_acc     = acc_shift;
                st_next.field_count = cnt1;
                if (cnt1 >= LONG_LEN_BYTES) begin
                    st_next.field_count = 16'd0;
                    if (too_long) begin
                        err = ERR_F7_LONG;
                    end else begin
                        st_next.payload_len = acc_shift;
                        done                = 1'b1;
                        st_next.phase       = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                in_header = 1'b0;
            end
        endcase

        // Any failure overrides the advance and latches the code.
        if (err != ERR_NONE) begin
            st_next.saved_error = err;
            st_next.phase       = PH_ERROR;
            st_next.field_count = 16'd0;
            status              = ST_ERROR;
        end

        offset_next = off;
        if (in_header && (off != {SIZE_WIDTH{1'b1}})) offset_next = off + SIZE_WIDTH'(1);
        fsize_next = fs;

        res.status         = status;
        res.error_code     = (status == ST_ERROR) ? st_next.saved_error : ERR_NONE;
        res.field_id       = field_of(cur.phase);
        res.out_byte       = data_byte;
        res.header_done    = done;
        res.payload_length = st_next.payload_len;
    end

endmodule

// ===== rtl/bitfile_header_parser.sv =====
// Bit file header parser: one result per byte, 1 byte/cycle sustained while m_tready is high.
// The input register feeds one pass of parse logic into the result register.
// Throughput is set by that single pass: one byte per cycle, no bubbles, while m_tready is high.
// Reset (aresetn low, synchronous) clears both stages and puts the parser in wait-for-start.
// Depends on bhp_pkg and bhp_parse.
module bitfile_header_parser import bhp_pkg::*; #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] total_bytes, [39:32] data_byte
    input  logic        s_tuser,   // [0] start_req
    // Result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [4:0] error_code, [7:5] field_id, [15:8] out_byte,
                                   // [16] header_done, [48:17] payload_length, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    // Input stage: holds one accepted request until the parse pass takes it.
    logic        in_valid_reg;
    logic        in_start_reg;
    logic [31:0] in_total_reg;
    logic [7:0]  in_byte_reg;

    // Parser state carried from byte to byte.
    parse_state_t          st_reg;
    parse_state_t          st_next;
    logic [SIZE_WIDTH-1:0] offset_reg;
    logic [SIZE_WIDTH-1:0] offset_next;
    logic [SIZE_WIDTH-1:0] fsize_reg;
    logic [SIZE_WIDTH-1:0] fsize_next;

    // Result stage.
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;

    logic advance;
    logic s_accept;

    // Advance a held request whenever the result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    bhp_parse #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_parse (
        .st_in       (st_reg),
        .offset_in   (offset_reg),
        .fsize_in    (fsize_reg),
        .start_req   (in_start_reg),
        .total_bytes (in_total_reg),
        .data_byte   (in_byte_reg),
        .st_next     (st_next),
        .offset_next (offset_next),
        .fsize_next  (fsize_next),
        .res         (res_next)
    );

    // Input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_start_reg <= s_tuser;
            in_total_reg <= s_tdata[31:0];
            in_byte_reg  <= s_tdata[39:32];
        end
    end

    // Parser state: update only when a byte moves into the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= STATE_RESET;
            offset_reg <= '0;
            fsize_reg  <= '0;
        end else if (advance) begin
            st_reg     <= st_next;
            offset_reg <= offset_next;
            fsize_reg  <= fsize_next;
        end
    end

    // Result stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result stage payload: hold while stalled.
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {7'd0,
                       res_reg.payload_length,
                       res_reg.header_done,
                       res_reg.out_byte,
                       res_reg.field_id,
                       res_reg.error_code};

`ifndef NO_ASSERTIONS
    // Header completion is only reported on a clean field 7 byte.
    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.header_done |->
            res_reg.status == ST_HEADER && res_reg.field_id == 3'd7)
        else $error("header_done on a byte outside field 7 or not a header byte");

    // An error result always carries a code.
    a_err_coded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && res_reg.status == ST_ERROR |-> res_reg.error_code != ERR_NONE)
        else $error("error status without an error code");

    // Payload bytes never move the header offset.
    a_payload_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_start_reg && st_reg.phase == PH_PAYLOAD |=> $stable(offset_reg))
        else $error("offset moved on a payload byte");
`endif

endmodule
